// ===== sv/serial_line_deframer_defines.svh =====
// Assertion macros for the serial line deframer.
`ifndef SERIAL_LINE_DEFRAMER_DEFINES_SVH
`define SERIAL_LINE_DEFRAMER_DEFINES_SVH

// Implication that must hold at every edge out of reset.
`define SLD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SLD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sld_pkg.sv =====
`default_nettype none
package sld_pkg;
    localparam int LINE_BYTES  = 1024;
    localparam int QUEUE_LINES = 32;
    localparam int SEQ_BYTES   = 4;
    localparam int SLOTS       = QUEUE_LINES + 1;
    localparam int WIN         = (SEQ_BYTES < 4) ? SEQ_BYTES : 4;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int OFF_W       = $clog2(LINE_BYTES);
    localparam int STORE_DEPTH = SLOTS * LINE_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int CNT_MAX     = 2047;

    typedef enum logic [1:0] {
        MODE_RX   = 2'd0,
        MODE_TICK = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_QUEUED   = 3'd1,
        EV_OVERFLOW = 3'd2,
        EV_TIMEOUT  = 3'd3,
        EV_READ     = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        REG_START_LEN   = 3'd0,
        REG_START_BYTES = 3'd1,
        REG_END_LEN     = 3'd2,
        REG_END_BYTES   = 3'd3,
        REG_SKIP        = 3'd4,
        REG_TIMEOUT     = 3'd5,
        REG_LINE_LIMIT  = 3'd6,
        REG_QUEUE_LIMIT = 3'd7
    } reg_idx_t;
endpackage
`default_nettype wire

// ===== sv/serial_line_deframer.sv =====
// Serial line deframer.
// Input beats on s_axis: tdata = {rx_byte[9:2], mode[1:0]}; mode 0 received
// byte, 1 timer tick, 2 read one byte of the oldest complete line, 3 nothing.
// Every input beat yields exactly one output beat on m_axis carrying
// event_res, read_byte, read_last, read_empty and lines_waiting.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the
// user must write it only while the block is idle; the block does not enforce it.
// Throughput: one beat per cycle when not stalled. Stage one captures an
// accepted beat and the output register then its result, from which it is
// taken. Stage one reads the line-length memory and the line store (one
// registered read port each); stage two finishes the step. A byte written
// to the store is forwarded when the next read hits the same entry.
// Reset (aresetn low, synchronous) empties the queue, closes any open line
// and restores register defaults; the memories are not cleared, since no
// entry is read before it is written.
// When m_axis_tready is low, the output register holds its beat and the
// pipeline stalls; s_axis_tready drops once the stages are full.
`default_nettype none
`include "serial_line_deframer_defines.svh"
module serial_line_deframer
    import sld_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // mode[1:0], rx_byte[9:2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_res[2:0], read_byte[10:3], read_last[11], read_empty[12],
    // lines_waiting[18:13]
    output logic [23:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    // configuration
    logic [2:0]  start_len_reg, end_len_reg;
    logic [31:0] start_bytes_reg, end_bytes_reg;
    logic [8:0]  skip_reg;
    logic [15:0] timeout_reg;
    logic [9:0]  line_limit_reg;
    logic [5:0]  queue_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_len_reg   <= '0;
            start_bytes_reg <= '0;
            end_len_reg     <= 3'd1;
            end_bytes_reg   <= 32'd10;
            skip_reg        <= 9'd13;
            timeout_reg     <= 16'd1000;
            line_limit_reg  <= 10'd1000;
            queue_limit_reg <= 6'd20;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_LEN:   start_len_reg   <= cfg_data[2:0];
                REG_START_BYTES: start_bytes_reg <= cfg_data;
                REG_END_LEN:     end_len_reg     <= cfg_data[2:0];
                REG_END_BYTES:   end_bytes_reg   <= cfg_data;
                REG_SKIP:        skip_reg        <= cfg_data[8:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data[15:0];
                REG_LINE_LIMIT:  line_limit_reg  <= cfg_data[9:0];
                REG_QUEUE_LIMIT: queue_limit_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // stage flow
    logic       s1_valid_reg, out_valid_reg;
    logic [1:0] s1_mode_reg;
    logic [7:0] s1_byte_reg;
    logic       adv_out, adv_s1, take_in;

    assign adv_out       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || adv_out;
    assign take_in       = s_axis_tvalid && s_axis_tready;
    assign adv_s1        = take_in;

    // queue state (read side tracked so stage-one addresses are correct)
    logic              in_line_reg;
    logic [31:0]       recent_reg;
    logic [CNT_W-1:0]  pending_reg, content_reg;
    logic [15:0]       timer_reg;
    logic [SLOT_W-1:0] head_reg, tail_reg;
    logic [5:0]        count_reg;
    logic [OFF_W:0]    roff_reg;

    // memories: read addressed from state as it stands when stage one
    // captures; state updates only in stage two, so stage-one reads see the
    // registered state of the preceding step, with forwarding below.
    logic                len_we, store_we;
    logic [SLOT_W-1:0]   len_waddr;
    logic [CNT_W-1:0]    len_wdata, len_rdata;
    logic [STORE_AW-1:0] store_waddr, store_raddr;
    logic [7:0]          store_wdata, store_rdata;
    logic [SLOT_W-1:0]   len_raddr;
    logic [SLOT_W-1:0]   head_next;
    logic [OFF_W:0]      roff_next;
    logic                len_fwd_reg, store_fwd_reg;
    logic [CNT_W-1:0]    len_fwd_data_reg;
    logic [7:0]          store_fwd_data_reg;

    // addresses follow the state that stage two will leave this cycle
    assign len_raddr   = adv_out ? head_next : head_reg;
    assign store_raddr = STORE_AW'(32'(len_raddr) * LINE_BYTES)
                       + STORE_AW'((adv_out ? roff_next : roff_reg) % LINE_BYTES);

    sld_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (adv_s1),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    sld_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store_ram (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (adv_s1),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv_s1) begin
            s1_valid_reg <= 1'b1;
        end else if (adv_out) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_s1) begin
            s1_mode_reg        <= s_axis_tdata[1:0];
            s1_byte_reg        <= s_axis_tdata[9:2];
            len_fwd_reg        <= len_we && (len_waddr == len_raddr);
            len_fwd_data_reg   <= len_wdata;
            store_fwd_reg      <= store_we && (store_waddr == store_raddr);
            store_fwd_data_reg <= store_wdata;
        end
    end

    logic [CNT_W-1:0] head_len;
    logic [7:0]       head_byte;
    assign head_len  = len_fwd_reg ? len_fwd_data_reg : len_rdata;
    assign head_byte = store_fwd_reg ? store_fwd_data_reg : store_rdata;

    // stage two: the step
    logic [2:0] ls, le;
    assign ls = (start_len_reg > 3'(WIN)) ? 3'(WIN) : start_len_reg;
    assign le = (end_len_reg == 3'd0) ? 3'd1
              : ((end_len_reg > 3'(WIN)) ? 3'(WIN) : end_len_reg);

    function automatic logic seq_hit(input logic [31:0] win, input logic [31:0] pat,
                                     input logic [2:0] len);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < len) begin
                if (pat[8*i +: 8] != win[8*(32'(len) - 1 - i) +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    logic              in_line_next;
    logic [31:0]       recent_next;
    logic [CNT_W-1:0]  pending_next, content_next;
    logic [15:0]       timer_next;
    logic [SLOT_W-1:0] tail_next;
    logic [5:0]        count_next;
    logic [2:0]        ev;
    logic [7:0]        rbyte;
    logic              rlast, rempty;
    logic [5:0]        qlim;
    logic [7:0]        c;

    assign qlim = (queue_limit_reg > 6'(QUEUE_LINES)) ? 6'(QUEUE_LINES) : queue_limit_reg;

    always_comb begin
        in_line_next = in_line_reg;
        recent_next  = recent_reg;
        pending_next = pending_reg;
        content_next = content_reg;
        timer_next   = timer_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        roff_next    = roff_reg;
        ev           = EV_NONE;
        rbyte        = '0;
        rlast        = 1'b0;
        rempty       = 1'b0;
        len_we       = 1'b0;
        len_waddr    = tail_reg;
        len_wdata    = content_reg;
        store_we     = 1'b0;
        store_waddr  = STORE_AW'(32'(tail_reg) * LINE_BYTES)
                     + STORE_AW'(content_reg[OFF_W-1:0]);
        c            = recent_reg[8*(32'(le) - 1) +: 8];
        store_wdata  = c;
        case (s1_mode_reg)
            MODE_RX: begin
                if (!in_line_next && ls == 3'd0) begin
                    in_line_next = 1'b1;
                    pending_next = '0;
                    content_next = '0;
                    recent_next  = '0;
                end
                if (!in_line_next) begin
                    recent_next = {recent_next[23:0], s1_byte_reg};
                    if (pending_next != CNT_W'(CNT_MAX)) pending_next = pending_next + 1'b1;
                    if (ls != 3'd0 && pending_next >= CNT_W'(ls)
                        && seq_hit(recent_next, start_bytes_reg, ls)) begin
                        in_line_next = 1'b1;
                        pending_next = '0;
                        content_next = '0;
                        recent_next  = '0;
                    end
                end else begin
                    if (pending_next >= CNT_W'(le)) begin
                        if ({1'b0, c} != skip_reg) begin
                            if (content_next < CNT_W'(LINE_BYTES)) store_we = adv_out;
                            if (content_next != CNT_W'(CNT_MAX))
                                content_next = content_next + 1'b1;
                        end
                    end
                    recent_next = {recent_next[23:0], s1_byte_reg};
                    if (pending_next != CNT_W'(CNT_MAX)) pending_next = pending_next + 1'b1;
                    if (pending_next >= CNT_W'(le) && seq_hit(recent_next, end_bytes_reg, le)) begin
                        if (content_next > CNT_W'(line_limit_reg)
                            || content_next > CNT_W'(LINE_BYTES)) begin
                            ev = EV_OVERFLOW;
                        end else if (count_reg >= qlim) begin
                            ev = EV_OVERFLOW;
                        end else begin
                            len_we    = adv_out;
                            len_wdata = content_next;
                            tail_next = (tail_reg == SLOT_W'(SLOTS - 1)) ? '0
                                      : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                            ev = EV_QUEUED;
                        end
                        in_line_next = (ls == 3'd0);
                        pending_next = '0;
                        content_next = '0;
                        recent_next  = '0;
                    end
                end
                if (pending_next > CNT_W'(line_limit_reg)) begin
                    in_line_next = 1'b0;
                    pending_next = '0;
                    content_next = '0;
                    recent_next  = '0;
                    ev = EV_OVERFLOW;
                end
                timer_next = (in_line_next && timeout_reg != 16'd0) ? timeout_reg : 16'd0;
            end
            MODE_TICK: begin
                if (timer_reg != 16'd0) begin
                    timer_next = timer_reg - 1'b1;
                    if (timer_next == 16'd0 && in_line_reg) begin
                        in_line_next = 1'b0;
                        pending_next = '0;
                        content_next = '0;
                        recent_next  = '0;
                        ev = EV_TIMEOUT;
                    end
                end
            end
            MODE_READ: begin
                ev = EV_READ;
                if (count_reg == 6'd0) begin
                    rempty = 1'b1;
                end else begin
                    if (head_len == '0) begin
                        rempty = 1'b1;
                    end else begin
                        rbyte     = head_byte;
                        roff_next = roff_reg + 1'b1;
                    end
                    if (CNT_W'(roff_next) >= head_len) begin
                        rlast      = 1'b1;
                        roff_next  = '0;
                        head_next  = (head_reg == SLOT_W'(SLOTS - 1)) ? '0
                                   : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    logic [23:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_line_reg   <= 1'b0;
            recent_reg    <= '0;
            pending_reg   <= '0;
            content_reg   <= '0;
            timer_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            roff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv_out) begin
                in_line_reg   <= in_line_next;
                recent_reg    <= recent_next;
                pending_reg   <= pending_next;
                content_reg   <= content_next;
                timer_reg     <= timer_next;
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                roff_reg      <= roff_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            out_data_reg <= {5'd0, count_next, rempty, rlast, rbyte, ev};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `SLD_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= 6'(QUEUE_LINES),
        "queue count above capacity")
    `SLD_ASSERT_IMP(a_hold_out, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        !adv_out, "output overwritten while stalled")
    `SLD_ASSERT_NEXT(a_read_empty_q, aclk, aresetn,
        adv_out && s1_mode_reg == MODE_READ && count_reg == 6'd0,
        m_axis_tdata[12] && !m_axis_tdata[11], "read of empty queue misreported")
endmodule
`default_nettype wire

// ===== sv/sld_ram.sv =====
`default_nettype none
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb_serial_line_deframer.sv =====
`default_nettype none
module tb_serial_line_deframer;
    import sld_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] rbyte;
        logic       last;
        logic       empty;
        logic [5:0] lines;
    } line_res_t;

    typedef struct {
        mode_t     mode;
        logic [7:0] data;
        bit        typed;
        line_res_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    serial_line_deframer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Shadow of the configuration registers
    logic [2:0]  sh_start_len, sh_end_len;
    logic [31:0] sh_start_bytes, sh_end_bytes;
    logic [8:0]  sh_skip;
    logic [15:0] sh_timeout;
    logic [9:0]  sh_line_limit;
    logic [5:0]  sh_queue_limit;

    // Deframer state as the predictor tracks it
    bit          ln_open;
    logic [31:0] ln_recent;
    int unsigned ln_pending, ln_content, ln_timer;
    int unsigned q_head, q_tail, q_count, rd_offset;
    logic [7:0]  line_mem [SLOTS*LINE_BYTES];
    int unsigned line_len [SLOTS];

    line_res_t   pending_lines [$];
    int          errors = 0;
    int unsigned cycles = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          hold_req = 1'b0;
    int          hold_cnt = 0;
    int          stall_cnt = 0;

    task automatic report(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        errors++;
    endtask

    function automatic int unsigned seq_window(input logic [2:0] len);
        return (len > WIN) ? WIN : len;
    endfunction

    function automatic bit seq_hit(input logic [31:0] bytes, input int unsigned len);
        for (int i = 0; i < len; i++) begin
            if (bytes[8*i +: 8] != ln_recent[8*(len-1-i) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void drop_line();
        ln_pending = 0;
        ln_content = 0;
        ln_recent  = '0;
    endfunction

    function automatic void shift_in(input logic [7:0] b);
        ln_recent = {ln_recent[23:0], b};
        if (ln_pending < CNT_MAX) ln_pending++;
    endfunction

    function automatic void deframer_reset();
        sh_start_len = 0; sh_start_bytes = 0; sh_end_len = 1; sh_end_bytes = 10;
        sh_skip = 13; sh_timeout = 1000; sh_line_limit = 1000; sh_queue_limit = 20;
        ln_open = 0; drop_line(); ln_timer = 0;
        q_head = 0; q_tail = 0; q_count = 0; rd_offset = 0;
    endfunction

    function automatic logic [2:0] close_line();
        logic [2:0] ev;
        int unsigned qlim;
        qlim = (sh_queue_limit > QUEUE_LINES) ? QUEUE_LINES : sh_queue_limit;
        if (ln_content > sh_line_limit || ln_content > LINE_BYTES || q_count >= qlim) begin
            ev = EV_OVERFLOW;
        end else begin
            line_len[q_tail] = ln_content;
            q_tail = (q_tail + 1) % SLOTS;
            q_count++;
            ev = EV_QUEUED;
        end
        ln_open = (seq_window(sh_start_len) == 0);
        drop_line();
        return ev;
    endfunction

    function automatic logic [2:0] rx_byte_step(input logic [7:0] b);
        logic [2:0] ev;
        int unsigned ls, le;
        logic [7:0] c;
        ev = EV_NONE;
        ls = seq_window(sh_start_len);
        le = seq_window(sh_end_len);
        if (le == 0) le = 1;
        if (!ln_open && ls == 0) begin
            ln_open = 1;
            drop_line();
        end
        if (!ln_open) begin
            shift_in(b);
            if (ls > 0 && ln_pending >= ls && seq_hit(sh_start_bytes, ls)) begin
                ln_open = 1;
                drop_line();
            end
        end else begin
            if (ln_pending >= le) begin
                // oldest byte of the window is no longer part of a possible end mark
                c = ln_recent[8*(le-1) +: 8];
                if ({1'b0, c} != sh_skip) begin
                    if (ln_content < LINE_BYTES) line_mem[q_tail*LINE_BYTES + ln_content] = c;
                    if (ln_content < CNT_MAX) ln_content++;
                end
            end
            shift_in(b);
            if (ln_pending >= le && seq_hit(sh_end_bytes, le)) ev = close_line();
        end
        if (ln_pending > sh_line_limit) begin
            ln_open = 0;
            drop_line();
            ev = EV_OVERFLOW;
        end
        ln_timer = (ln_open && sh_timeout > 0) ? sh_timeout : 0;
        return ev;
    endfunction

    function automatic line_res_t deframer_step(input mode_t mode, input logic [7:0] b);
        line_res_t r;
        int unsigned len;
        r = '0;
        case (mode)
            MODE_RX: r.ev = rx_byte_step(b);
            MODE_TICK: begin
                if (ln_timer > 0) begin
                    ln_timer--;
                    if (ln_timer == 0 && ln_open) begin
                        ln_open = 0;
                        drop_line();
                        r.ev = EV_TIMEOUT;
                    end
                end
            end
            MODE_READ: begin
                r.ev = EV_READ;
                if (q_count == 0) begin
                    r.empty = 1;
                end else begin
                    len = line_len[q_head];
                    if (len == 0) begin
                        r.empty = 1;
                    end else begin
                        r.rbyte = line_mem[q_head*LINE_BYTES + (rd_offset % LINE_BYTES)];
                        rd_offset++;
                    end
                    if (rd_offset >= len) begin
                        r.last = 1;
                        rd_offset = 0;
                        q_head = (q_head + 1) % SLOTS;
                        q_count--;
                    end
                end
            end
            default: ;
        endcase
        r.lines = q_count[5:0];
        return r;
    endfunction

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            REG_START_LEN:   sh_start_len   = val[2:0];
            REG_START_BYTES: sh_start_bytes = val;
            REG_END_LEN:     sh_end_len     = val[2:0];
            REG_END_BYTES:   sh_end_bytes   = val;
            REG_SKIP:        sh_skip        = val[8:0];
            REG_TIMEOUT:     sh_timeout     = val[15:0];
            REG_LINE_LIMIT:  sh_line_limit  = val[9:0];
            REG_QUEUE_LIMIT: sh_queue_limit = val[5:0];
            default: ;
        endcase
    endtask

    // Hold valid across back-to-back beats; lower it only for a gap.
    task automatic send_beat(input mode_t mode, input logic [7:0] b, input bit typed,
                             input line_res_t want);
        int gap;
        line_res_t got_pred;
        gap = 0;
        if (gaps_on) begin
            gap = $urandom_range(0, 99);
            gap = (gap < 55) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, b, mode};
        do @(posedge aclk); while (!s_axis_tready);
        got_pred = deframer_step(mode, b);
        pending_lines.push_back(typed ? want : got_pred);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Result side: random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_cnt = 300;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_axis_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 15) begin
            stall_cnt = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                     : $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        line_res_t want, got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{ev: m_axis_tdata[2:0], rbyte: m_axis_tdata[10:3], last: m_axis_tdata[11],
                    empty: m_axis_tdata[12], lines: m_axis_tdata[18:13]};
            if (pending_lines.size() == 0) begin
                report($sformatf("unexpected beat %h", m_axis_tdata));
            end else begin
                want = pending_lines.pop_front();
                if (got.ev != want.ev)
                    report($sformatf("event_res %0d, want %0d", got.ev, want.ev));
                if (got.rbyte != want.rbyte)
                    report($sformatf("read_byte %h, want %h", got.rbyte, want.rbyte));
                if (got.last != want.last)
                    report($sformatf("read_last %0d, want %0d", got.last, want.last));
                if (got.empty != want.empty)
                    report($sformatf("read_empty %0d, want %0d", got.empty, want.empty));
                if (got.lines != want.lines)
                    report($sformatf("lines_waiting %0d, want %0d", got.lines, want.lines));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic line_res_t mk(input event_t ev, input logic [7:0] b, input bit last,
                                     input bit empty, input logic [5:0] lines);
        return '{ev: ev, rbyte: b, last: last, empty: empty, lines: lines};
    endfunction

    initial begin
        stim_row_t  rows [$];
        logic [7:0] plan_data [$];
        mode_t      plan_mode [$];
        logic [7:0] b;
        int unsigned ls, le, k, n, pick;

        deframer_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset configuration: lines end on LF, CR is dropped
        rows.push_back('{MODE_READ, 8'h00, 1, mk(EV_READ, 0, 0, 1, 0)});
        rows.push_back('{MODE_TICK, 8'h00, 1, mk(EV_NONE, 0, 0, 0, 0)});
        rows.push_back('{MODE_NONE, 8'hFF, 1, mk(EV_NONE, 0, 0, 0, 0)});
        rows.push_back('{MODE_RX,   8'h41, 1, mk(EV_NONE, 0, 0, 0, 0)});
        rows.push_back('{MODE_RX,   8'h0D, 1, mk(EV_NONE, 0, 0, 0, 0)});
        rows.push_back('{MODE_RX,   8'h00, 1, mk(EV_NONE, 0, 0, 0, 0)});
        rows.push_back('{MODE_RX,   8'hFF, 1, mk(EV_NONE, 0, 0, 0, 0)});
        rows.push_back('{MODE_RX,   8'h0A, 1, mk(EV_QUEUED, 0, 0, 0, 1)});
        rows.push_back('{MODE_RX,   8'h0A, 1, mk(EV_QUEUED, 0, 0, 0, 2)});
        rows.push_back('{MODE_READ, 8'h00, 1, mk(EV_READ, 8'h41, 0, 0, 2)});
        rows.push_back('{MODE_READ, 8'h00, 1, mk(EV_READ, 8'h00, 0, 0, 2)});
        rows.push_back('{MODE_READ, 8'h00, 1, mk(EV_READ, 8'hFF, 1, 0, 1)});
        rows.push_back('{MODE_READ, 8'h00, 1, mk(EV_READ, 8'h00, 1, 1, 0)});
        rows.push_back('{MODE_READ, 8'h00, 1, mk(EV_READ, 8'h00, 0, 1, 0)});
        rows.push_back('{MODE_RX,   8'h5A, 0, '0});
        rows.push_back('{MODE_TICK, 8'h00, 0, '0});
        rows.push_back('{MODE_RX,   8'hA5, 0, '0});
        rows.push_back('{MODE_RX,   8'h0A, 0, '0});
        rows.push_back('{MODE_READ, 8'h00, 0, '0});
        rows.push_back('{MODE_READ, 8'h00, 0, '0});
        foreach (rows[i]) send_beat(rows[i].mode, rows[i].data, rows[i].typed, rows[i].want);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                reg_write(REG_START_LEN, 0);   reg_write(REG_START_BYTES, 0);
                reg_write(REG_END_LEN, 0);     reg_write(REG_END_BYTES, 0);
                reg_write(REG_SKIP, 0);        reg_write(REG_TIMEOUT, 0);
                reg_write(REG_LINE_LIMIT, 0);  reg_write(REG_QUEUE_LIMIT, 0);
            end else if (p == 1) begin
                reg_write(REG_START_LEN, 7);   reg_write(REG_START_BYTES, 32'hFFFF_FFFF);
                reg_write(REG_END_LEN, 7);     reg_write(REG_END_BYTES, 32'hFFFF_FFFF);
                reg_write(REG_SKIP, 511);      reg_write(REG_TIMEOUT, 16'hFFFF);
                reg_write(REG_LINE_LIMIT, 1023); reg_write(REG_QUEUE_LIMIT, 63);
            end else begin
                pick = $urandom_range(0, 6);
                reg_write(REG_START_LEN, (pick > 4) ? $urandom_range(0, 7) : pick);
                reg_write(REG_START_BYTES, $urandom);
                reg_write(REG_END_LEN, $urandom_range(0, 7));
                reg_write(REG_END_BYTES, $urandom);
                pick = $urandom_range(0, 3);
                reg_write(REG_SKIP, (pick == 0) ? 256 : (pick == 1) ? $urandom_range(256, 511)
                                                                     : $urandom_range(0, 255));
                pick = $urandom_range(0, 3);
                reg_write(REG_TIMEOUT, (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 3)
                                                                      : $urandom_range(4, 20));
                pick = $urandom_range(0, 5);
                reg_write(REG_LINE_LIMIT, (pick == 0) ? 3 : (pick == 1) ? 1020
                                                          : $urandom_range(8, 60));
                pick = $urandom_range(0, 4);
                reg_write(REG_QUEUE_LIMIT, (pick == 0) ? 1 : (pick == 1) ? 32
                                                           : $urandom_range(2, 31));
            end
            cfg_we <= 1'b0;
            @(posedge aclk);

            gaps_on   = (p % 3) != 2;
            stalls_on = (p % 4) != 3;
            if (p == 3) begin
                gaps_on  = 0;
                hold_req = 1'b1;
            end

            ls = seq_window(sh_start_len);
            le = seq_window(sh_end_len);
            if (le == 0) le = 1;
            n = (p == 0) ? 40 : 110;
            for (int it = 0; it < n; ) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    for (int j = 0; j < ls; j++) begin
                        plan_mode.push_back(MODE_RX); plan_data.push_back(sh_start_bytes[8*j +: 8]);
                    end
                    k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
                    for (int j = 0; j < k; j++) begin
                        b = ($urandom_range(0, 3) == 0) ? sh_skip[7:0] : 8'($urandom);
                        plan_mode.push_back(MODE_RX); plan_data.push_back(b);
                    end
                    for (int j = 0; j < le; j++) begin
                        plan_mode.push_back(MODE_RX); plan_data.push_back(sh_end_bytes[8*j +: 8]);
                    end
                    repeat ($urandom_range(0, k + 2)) begin
                        plan_mode.push_back(MODE_READ); plan_data.push_back(8'($urandom));
                    end
                end else if (pick < 75) begin
                    repeat ($urandom_range(1, 6)) begin
                        plan_mode.push_back(MODE_TICK); plan_data.push_back(8'($urandom));
                    end
                end else if (pick < 90) begin
                    repeat ($urandom_range(1, 4)) begin
                        plan_mode.push_back(MODE_READ); plan_data.push_back(8'($urandom));
                    end
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        plan_mode.push_back(mode_t'($urandom_range(0, 3)));
                        plan_data.push_back(8'($urandom));
                    end
                end
                while (plan_mode.size() != 0) begin
                    send_beat(plan_mode.pop_front(), plan_data.pop_front(), 1'b0, '0);
                    it++;
                end
                // pause mid-phase until the result side has caught up
                if (p == 4 && it >= n / 2 && it < n / 2 + 8) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_lines.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
